/* rtl/rdr_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rdr_pkg: shared types and constants of the record deque ring
// Command and status codes, field widths, defaults and controller commands.
// ---------------------------------------------------------------------------
package rdr_pkg;

    // Parameter defaults
    localparam int unsigned DEPTH_DEF       = 16;
    localparam int unsigned RECORD_BITS_DEF = 64;

    // Fixed port field widths
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned REC_W    = 64;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TOTAL_W  = 5;

    // Command codes; six and seven are no operation
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_READ_FRONT = 3'd3,
        CMD_READ_BACK  = 3'd4,
        CMD_READ_POS   = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the input transaction, update ring, access store
        logic load;     // capture the finished result into the output register
    } ctrl_cmd_t;

endpackage : rdr_pkg
`default_nettype wire

/* rtl/record_deque_ring_top.sv */
`default_nettype none
// A result is held in the pending status and store read registers, then loaded
//   into the output register once that register is free or being drained.
// A new command is not taken until the result of the last one has been loaded.
// The next command is taken while an earlier result waits in the output register.
// Reset clears front index, entry count, sequencer and output valid; the
//   record store is not cleared.
// ---------------------------------------------------------------------------
// record_deque_ring_top: bounded double-ended queue on a ring store
// Push front/back, pop back, read front/back/position; one result each.
// ---------------------------------------------------------------------------
module record_deque_ring_top
#(
    parameter int unsigned DEPTH       = rdr_pkg::DEPTH_DEF,
    parameter int unsigned RECORD_BITS = rdr_pkg::RECORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rdr_pkg::CMD_W-1:0]     command,
    input  wire logic [rdr_pkg::REC_W-1:0]     record_in,
    input  wire logic [rdr_pkg::POS_W-1:0]     position,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rdr_pkg::STATUS_W-1:0]       status,
    output logic [rdr_pkg::REC_W-1:0]          record_out,
    output logic [rdr_pkg::TOTAL_W-1:0]        entry_total
);

    rdr_pkg::ctrl_cmd_t cmd;

    // Sequence transactions
    rdr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Ring store and result path
    rdr_datapath
    #(
        .DEPTH       (DEPTH),
        .RECORD_BITS (RECORD_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .command     (command),
        .record_in   (record_in),
        .position    (position),
        .status      (status),
        .record_out  (record_out),
        .entry_total (entry_total)
    );

endmodule : record_deque_ring_top
`default_nettype wire

/* rtl/rdr_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rdr_ctrl: controller of the record deque ring
// Two-state sequencer: accept a command, then load its result into the
// output register once that register is free or being drained.
// ---------------------------------------------------------------------------
module rdr_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rdr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Decode handshakes into datapath commands
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.accept = in_valid && (state_reg == ST_IDLE);
        cmd.load   = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cmd.load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output valid until the transaction is taken
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : rdr_ctrl
`default_nettype wire

/* rtl/rdr_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rdr_datapath: ring store and index datapath of the record deque ring
// Front index and entry count, slot address arithmetic, the record store
// with a registered read port, and the output result register.
// ---------------------------------------------------------------------------
module rdr_datapath
#(
    parameter int unsigned DEPTH       = rdr_pkg::DEPTH_DEF,
    parameter int unsigned RECORD_BITS = rdr_pkg::RECORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rdr_pkg::ctrl_cmd_t            cmd,
    input  wire logic [rdr_pkg::CMD_W-1:0]     command,
    input  wire logic [rdr_pkg::REC_W-1:0]     record_in,
    input  wire logic [rdr_pkg::POS_W-1:0]     position,
    output logic [rdr_pkg::STATUS_W-1:0]       status,
    output logic [rdr_pkg::REC_W-1:0]          record_out,
    output logic [rdr_pkg::TOTAL_W-1:0]        entry_total
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > rdr_pkg::POS_W) ? CW : rdr_pkg::POS_W;

    // Ring state
    logic [AW-1:0]          front_reg;
    logic [AW-1:0]          front_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // Per-command pending result
    rdr_pkg::status_t       stat_pend_reg;
    rdr_pkg::status_t       stat_d;
    logic                   rd_flag_reg;

    // Store and its registered read data
    logic [RECORD_BITS-1:0] mem [DEPTH];
    logic [RECORD_BITS-1:0] rd_data_reg;

    // Output register
    rdr_pkg::status_t       out_stat_reg;
    logic [RECORD_BITS-1:0] out_rec_reg;
    logic [rdr_pkg::TOTAL_W-1:0] out_total_reg;

    logic                   full;
    logic                   empty;
    logic [AW-1:0]          front_dec;
    logic [CW-1:0]          cnt_m1;
    logic [XW-1:0]          cnt_ext;
    logic [XW-1:0]          pos_ext;
    logic [XW-1:0]          pos_m1;
    logic [AW-1:0]          off;
    logic [AW:0]            slot_sum;
    logic [AW-1:0]          slot;
    logic [AW-1:0]          addr;
    logic                   sel_front;
    logic                   wr_en;
    logic                   rd_en;

    // Derive ring helpers
    always_comb
    begin
        full      = (count_reg == CW'(DEPTH));
        empty     = (count_reg == '0);
        front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : (front_reg - AW'(1));
        cnt_m1    = count_reg - CW'(1);
        cnt_ext   = XW'(count_reg);
        pos_ext   = XW'(position);
        pos_m1    = pos_ext - XW'(1);
    end

    // Decode the command into status, ring update and store access
    always_comb
    begin
        stat_d     = rdr_pkg::STAT_OK;
        front_next = front_reg;
        count_next = count_reg;
        off        = '0;
        sel_front  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        case (rdr_pkg::cmd_t'(command))
            rdr_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                    stat_d = rdr_pkg::STAT_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    sel_front  = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            rdr_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                    stat_d = rdr_pkg::STAT_FULL;
                else
                begin
                    wr_en      = 1'b1;
                    off        = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            rdr_pkg::CMD_POP_BACK:
            begin
                if (empty)
                    stat_d = rdr_pkg::STAT_EMPTY;
                else
                    count_next = cnt_m1;
            end
            rdr_pkg::CMD_READ_FRONT:
            begin
                if (empty)
                    stat_d = rdr_pkg::STAT_EMPTY;
                else
                    rd_en = 1'b1;
            end
            rdr_pkg::CMD_READ_BACK:
            begin
                if (empty)
                    stat_d = rdr_pkg::STAT_EMPTY;
                else
                begin
                    rd_en = 1'b1;
                    off   = cnt_m1[AW-1:0];
                end
            end
            rdr_pkg::CMD_READ_POS:
            begin
                if (empty)
                    stat_d = rdr_pkg::STAT_EMPTY;
                else if ((pos_ext == '0) || (pos_ext > cnt_ext))
                    stat_d = rdr_pkg::STAT_RANGE;
                else
                begin
                    rd_en = 1'b1;
                    off   = pos_m1[AW-1:0];
                end
            end
            default:
            begin
                stat_d = rdr_pkg::STAT_OK;
            end
        endcase
    end

    // Wrap front plus offset into a ring slot
    always_comb
    begin
        slot_sum = {1'b0, front_reg} + {1'b0, off};
        if (slot_sum >= (AW + 1)'(DEPTH))
            slot = AW'(slot_sum - (AW + 1)'(DEPTH));
        else
            slot = slot_sum[AW-1:0];
        addr = sel_front ? front_dec : slot;
    end

    // Advance ring indices on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Hold the pending status and read flag
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stat_pend_reg <= stat_d;
            rd_flag_reg   <= rd_en;
        end
    end

    // Store: one shared address for write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            mem[addr] <= record_in[RECORD_BITS-1:0];
        if (cmd.accept && rd_en)
            rd_data_reg <= mem[addr];
    end

    // Load the result into the output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_stat_reg  <= stat_pend_reg;
            out_rec_reg   <= rd_flag_reg ? rd_data_reg : '0;
            out_total_reg <= cnt_ext[rdr_pkg::TOTAL_W-1:0];
        end
    end

    assign status      = out_stat_reg;
    assign record_out  = rdr_pkg::REC_W'(out_rec_reg);
    assign entry_total = out_total_reg;

endmodule : rdr_datapath
`default_nettype wire

/* rtl/rdr_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// rdr_checker: port-level checks of the record deque ring
// Watches the top-level ports over time; attached by bind below.
// ---------------------------------------------------------------------------
module rdr_checker
#(
    parameter int unsigned DEPTH = rdr_pkg::DEPTH_DEF
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [rdr_pkg::STATUS_W-1:0]  status,
    input wire logic [rdr_pkg::REC_W-1:0]     record_out,
    input wire logic [rdr_pkg::TOTAL_W-1:0]   entry_total
);

    // One command at a time: ready drops after an accepted transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    // Failed commands carry no record
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != rdr_pkg::STAT_OK)) |-> (record_out == '0))
        else $error("record present on a flagged result");

    // A full push reports a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == rdr_pkg::STAT_FULL))
            |-> (entry_total == rdr_pkg::TOTAL_W'(DEPTH)))
        else $error("full status with count below depth");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready)
            |=> (out_valid && $stable(status) && $stable(record_out)
                 && $stable(entry_total)))
        else $error("stalled result changed");

endmodule : rdr_checker

bind record_deque_ring_top rdr_checker #(.DEPTH(DEPTH)) u_rdr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .record_out  (record_out),
    .entry_total (entry_total)
);
`default_nettype wire

/* verif/tb_record_deque_ring_top.sv */
// ---------------------------------------------------------------------------
// tb_record_deque_ring_top: self-checking bench for the record deque ring
// Mirrors the ring deque in the bench and checks each result against a queue
// of predicted results. Directed empty, full and range cases come first. A
// long output stall and a sender pause follow, then random fill, drain and
// balanced phases.
// ---------------------------------------------------------------------------
module tb_record_deque_ring_top;

    localparam int unsigned RING_SLOTS  = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LONG_HOLD   = 250;

    // Unused command codes, treated as no operation
    localparam logic [rdr_pkg::CMD_W-1:0] CMD_NOP_SIX   = 3'd6;
    localparam logic [rdr_pkg::CMD_W-1:0] CMD_NOP_SEVEN = 3'd7;

    // Random phase shapes
    localparam int MODE_FILL     = 0;
    localparam int MODE_DRAIN    = 1;
    localparam int MODE_BALANCED = 2;

    typedef struct {
        rdr_pkg::status_t                st;
        logic [rdr_pkg::REC_W-1:0]       rec;
        logic [rdr_pkg::TOTAL_W-1:0]     total;
    } deque_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [rdr_pkg::CMD_W-1:0]    command;
    logic [rdr_pkg::REC_W-1:0]    record_in;
    logic [rdr_pkg::POS_W-1:0]    position;
    logic                         out_valid;
    logic                         out_ready;
    logic [rdr_pkg::STATUS_W-1:0] status;
    logic [rdr_pkg::REC_W-1:0]    record_out;
    logic [rdr_pkg::TOTAL_W-1:0]  entry_total;

    // Bench copy of the deque
    logic [rdr_pkg::REC_W-1:0]    mirror_store [RING_SLOTS];
    logic [3:0]                   mirror_front;
    logic [rdr_pkg::TOTAL_W-1:0]  mirror_count;

    deque_result_t       pending_results [$];
    deque_result_t       head_result;

    int unsigned         cycle_count;
    int unsigned         fail_count;
    int unsigned         n_sent;
    int unsigned         n_checked;
    int unsigned         n_full_hits;
    int unsigned         n_empty_hits;
    int unsigned         n_range_hits;

    bit                  tx_idle_on;
    bit                  rx_idle_on;
    bit                  long_hold_req;

    record_deque_ring_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .record_in   (record_in),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .record_out  (record_out),
        .entry_total (entry_total)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly short, a few long
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Record payload, with the extremes now and then
    function automatic logic [rdr_pkg::REC_W-1:0] rand_record();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '1;
        else if (r == 1)
            return '0;
        else
            return {$urandom(), $urandom()};
    endfunction

    // Advance the bench deque by one command and queue the expected result
    function automatic void predict_deque(input logic [rdr_pkg::CMD_W-1:0] c,
                                          input logic [rdr_pkg::REC_W-1:0] r,
                                          input logic [rdr_pkg::POS_W-1:0] p);
        deque_result_t res;
        res.st  = rdr_pkg::STAT_OK;
        res.rec = '0;
        case (c)
            rdr_pkg::CMD_PUSH_FRONT, rdr_pkg::CMD_PUSH_BACK:
            begin
                if (mirror_count >= RING_SLOTS)
                begin
                    res.st = rdr_pkg::STAT_FULL;
                end
                else if (c == rdr_pkg::CMD_PUSH_FRONT)
                begin
                    mirror_front = mirror_front - 4'd1;
                    mirror_store[mirror_front] = r;
                    mirror_count = mirror_count + rdr_pkg::TOTAL_W'(1);
                end
                else
                begin
                    mirror_store[4'(mirror_front + mirror_count)] = r;
                    mirror_count = mirror_count + rdr_pkg::TOTAL_W'(1);
                end
            end
            rdr_pkg::CMD_POP_BACK:
            begin
                if (mirror_count == 0)
                    res.st = rdr_pkg::STAT_EMPTY;
                else
                    mirror_count = mirror_count - rdr_pkg::TOTAL_W'(1);
            end
            rdr_pkg::CMD_READ_FRONT:
            begin
                if (mirror_count == 0)
                    res.st = rdr_pkg::STAT_EMPTY;
                else
                    res.rec = mirror_store[mirror_front];
            end
            rdr_pkg::CMD_READ_BACK:
            begin
                if (mirror_count == 0)
                    res.st = rdr_pkg::STAT_EMPTY;
                else
                    res.rec = mirror_store[4'(mirror_front + mirror_count - 1)];
            end
            rdr_pkg::CMD_READ_POS:
            begin
                if (mirror_count == 0)
                    res.st = rdr_pkg::STAT_EMPTY;
                else if (p == 0 || p > mirror_count)
                    res.st = rdr_pkg::STAT_RANGE;
                else
                    res.rec = mirror_store[4'(mirror_front + p - 1)];
            end
            default:
            begin
            end
        endcase
        res.total = mirror_count;
        case (res.st)
            rdr_pkg::STAT_FULL:  n_full_hits++;
            rdr_pkg::STAT_EMPTY: n_empty_hits++;
            rdr_pkg::STAT_RANGE: n_range_hits++;
            default:    ;
        endcase
        pending_results.push_back(res);
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_cmd(input logic [rdr_pkg::CMD_W-1:0] c,
                            input logic [rdr_pkg::REC_W-1:0] r,
                            input logic [rdr_pkg::POS_W-1:0] p);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 2) == 0)
            gap = rand_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command   = c;
        record_in = r;
        position  = p;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_deque(c, r, p);
        n_sent++;
    endtask

    // Position for a read: mostly inside the occupied region
    function automatic logic [rdr_pkg::POS_W-1:0] pick_position(
        input logic [rdr_pkg::CMD_W-1:0] c);
        if (c == rdr_pkg::CMD_READ_POS && mirror_count > 0 && $urandom_range(0, 9) < 7)
            return rdr_pkg::POS_W'($urandom_range(1, mirror_count));
        return rdr_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    // Command mix for one phase shape
    function automatic logic [rdr_pkg::CMD_W-1:0] pick_command(input int mode);
        int unsigned r;
        int unsigned push_pct;
        int unsigned pop_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  begin push_pct = 60; pop_pct = 14; end
            MODE_DRAIN: begin push_pct = 14; pop_pct = 60; end
            default:    begin push_pct = 36; pop_pct = 30; end
        endcase
        if (r < 2)
            return (r == 0) ? CMD_NOP_SIX : CMD_NOP_SEVEN;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 1) == 0) ? rdr_pkg::CMD_PUSH_FRONT
                                               : rdr_pkg::CMD_PUSH_BACK;
        if (r < push_pct + pop_pct)
            return rdr_pkg::CMD_POP_BACK;
        case ($urandom_range(0, 3))
            0:       return rdr_pkg::CMD_READ_FRONT;
            1:       return rdr_pkg::CMD_READ_BACK;
            default: return rdr_pkg::CMD_READ_POS;
        endcase
    endfunction

    task automatic send_random();
        logic [rdr_pkg::CMD_W-1:0] c;
        c = pick_command(MODE_BALANCED);
        send_cmd(c, rand_record(), pick_position(c));
    endtask

    // Hold the sender until every predicted result has been taken
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Empty queue: pops and every read flag empty; unused codes do nothing
    task automatic test_empty_queue();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_cmd(rdr_pkg::CMD_POP_BACK, '0, '0);
        send_cmd(rdr_pkg::CMD_READ_FRONT, '1, '1);
        send_cmd(rdr_pkg::CMD_READ_BACK, '0, '0);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, '0);
        send_cmd(rdr_pkg::CMD_READ_POS, '1, 5'd1);
        send_cmd(CMD_NOP_SIX, '1, '1);
        send_cmd(CMD_NOP_SEVEN, '0, '0);
    endtask

    // Both ends, position edges, fill to full and push past it
    task automatic test_fill_and_limits();
        int unsigned k;
        send_cmd(rdr_pkg::CMD_PUSH_BACK, '1, '0);
        send_cmd(rdr_pkg::CMD_PUSH_FRONT, '0, '1);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd1);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd2);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd0);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd3);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd31);
        send_cmd(rdr_pkg::CMD_READ_FRONT, '0, '0);
        send_cmd(rdr_pkg::CMD_READ_BACK, '0, '0);
        k = 0;
        while (mirror_count < RING_SLOTS)
        begin
            send_cmd((k % 2 == 0) ? rdr_pkg::CMD_PUSH_FRONT : rdr_pkg::CMD_PUSH_BACK,
                     {$urandom(), $urandom()}, '0);
            k++;
        end
        send_cmd(rdr_pkg::CMD_PUSH_FRONT, '1, '0);
        send_cmd(rdr_pkg::CMD_PUSH_BACK, '1, '0);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd16);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd17);
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) send_random();
    endtask

    // Sender pauses until idle, then drain to empty and pop once more
    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (12) send_random();
        wait_drained();
        while (mirror_count > 0)
            send_cmd(rdr_pkg::CMD_POP_BACK, rand_record(), '0);
        send_cmd(rdr_pkg::CMD_POP_BACK, '0, '0);
        send_cmd(rdr_pkg::CMD_READ_POS, '0, 5'd16);
    endtask

    // Random phases that sweep the count between empty and full
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned k;
        int unsigned phase_len;
        int          mode;
        logic [rdr_pkg::CMD_W-1:0] c;
        k = 0;
        while (k < n_items)
        begin
            mode       = $urandom_range(MODE_FILL, MODE_BALANCED);
            phase_len  = $urandom_range(20, 80);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat (phase_len)
            begin
                c = pick_command(mode);
                send_cmd(c, rand_record(), pick_position(c));
                k++;
            end
        end
    endtask

    // Receiver: long hold on request, otherwise random short and long gaps
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left  = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (gap_left > 0)
            begin
                out_ready = 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0)
                    gap_left = rand_gap();
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d record %h total %0d",
                       status, record_out, entry_total);
                fail_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                n_checked++;
                if (status !== head_result.st)
                begin
                    $error("status: expected %0d, actual %0d", head_result.st, status);
                    fail_count++;
                end
                if (record_out !== head_result.rec)
                begin
                    $error("record_out: expected %h, actual %h",
                           head_result.rec, record_out);
                    fail_count++;
                end
                if (entry_total !== head_result.total)
                begin
                    $error("entry_total: expected %0d, actual %0d",
                           head_result.total, entry_total);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = '0;
        record_in     = '0;
        position      = '0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b0;
        cycle_count   = 0;
        fail_count    = 0;
        n_sent        = 0;
        n_checked     = 0;
        n_full_hits   = 0;
        n_empty_hits  = 0;
        n_range_hits  = 0;
        mirror_front  = '0;
        mirror_count  = '0;
        foreach (mirror_store[i])
            mirror_store[i] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_queue();
        test_fill_and_limits();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix(1250);

        // Let the last results drain, then watch for strays
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d commands and checked %0d results", n_sent, n_checked);
        $display("full pushes %0d, empty accesses %0d, out-of-range reads %0d",
                 n_full_hits, n_empty_hits, n_range_hits);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
